FILE: design/assert_macros.svh
// Assertion macros shared by the grid occupancy map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gom_pkg.sv
// Shared types and constants of the grid occupancy map.
`timescale 1ns / 1ps

package gom_pkg;

    // Port field widths
    localparam int CMD_W   = 2;
    localparam int EID_W   = 10;
    localparam int POS_W   = 10;
    localparam int OFF_W   = 8;
    localparam int SIZE_W  = 9;
    localparam int DIR_W   = 2;
    localparam int RANGE_W = 6;

    // Pixel arithmetic: position + offset + size, plus sign
    localparam int PIX_W    = 13;
    // Biased, non-negative dividend fed to the cell divider
    localparam int DIV_IN_W = 12;
    // Signed cell coordinate, covers the grid plus probe overshoot
    localparam int COORD_W  = 12;

    typedef logic signed [PIX_W-1:0]   t_pix;
    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_PROBE  = 2'd3
    } t_cmd;

    typedef enum logic [DIR_W-1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

endpackage

FILE: design/gom_cell_div.sv
// Pipelined floor division of a pixel coordinate by the cell size.
`timescale 1ns / 1ps

module gom_cell_div #(
    parameter int CELL_SIZE = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gom_pkg::t_pix   i_pix,
    output logic            o_valid,
    output gom_pkg::t_coord o_cell
);

    localparam int IN_W       = gom_pkg::DIV_IN_W;
    // bias keeps negative pixels down to -BIAS_PIX (at least 256 below zero) non-negative
    localparam int BIAS_CELLS = (256 + CELL_SIZE - 1) / CELL_SIZE;
    localparam int BIAS_PIX   = BIAS_CELLS * CELL_SIZE;
    // ceil reciprocal with this shift is exact for every IN_W-bit dividend
    localparam int SHIFT      = IN_W + $clog2(CELL_SIZE);
    localparam int PROD_W     = SHIFT + IN_W;
    localparam logic [PROD_W-1:0] RECIP =
        PROD_W'(((1 << SHIFT) + CELL_SIZE - 1) / CELL_SIZE);

    logic [2:0]        r_vld;
    logic [IN_W-1:0]   r_u;
    logic [PROD_W-1:0] r_prod;
    gom_pkg::t_coord   r_cell;

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // bias, multiply by reciprocal, take quotient and remove bias
    always_ff @(posedge i_clk) begin
        r_u    <= IN_W'(i_pix + gom_pkg::t_pix'(BIAS_PIX));
        r_prod <= PROD_W'(PROD_W'(r_u) * RECIP);
        r_cell <= gom_pkg::t_coord'(r_prod[SHIFT +: IN_W])
                  - gom_pkg::t_coord'(BIAS_CELLS);
    end

    assign o_valid = r_vld[2];
    assign o_cell  = r_cell;

endmodule

FILE: design/gom_cell_mem.sv
// Cell table: one write port, one registered read port, clearing pass after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gom_cell_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata,
    output logic              o_ready
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // clearing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clr_busy;

    `CHK_IMPLY(a_rmw_no_overlap, i_clk, i_rst_n, i_we && i_re, i_waddr != i_raddr, "read and write hit the same cell in one cycle")
    `CHK_IMPLY(a_clear_quiet, i_clk, i_rst_n, r_clr_busy, !i_we && !i_re, "table access during clearing pass")

endmodule

FILE: design/grid_occupancy_map_top.sv
// Top level of the grid occupancy map: command capture, cell walk and result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Grid occupancy map. A command is taken when start is high and busy is low;
// its single result appears on o_hit / o_hit_id for exactly one cycle with
// o_result_valid, and must be taken then. After reset, busy stays high while
// the cell table is swept clear. From transfer to result strobe, a command
// passes through the four floor divisions of the span corners (of the start
// point for a probe) in the shared pipelined divider, then walks its cells:
// every in-grid cell of the rectangle for insert and remove, the cells up to
// and including the first foreign owner for an area query, and up to
// min(max_range, MAX_STEPS) steps for a probe. Empty rectangles and probes
// without a source or range skip the walk. The walk reads or writes one cell
// of the table per cycle. busy is low in the strobe cycle, so the next command
// may be taken there.
module grid_occupancy_map_top #(
    parameter int CELL_SIZE = 16,
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64,
    parameter int ID_BITS   = 10,
    parameter int MAX_STEPS = 63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gom_pkg::CMD_W-1:0]           i_cmd,
    input  logic [gom_pkg::EID_W-1:0]           i_entity_id,
    input  logic                                i_source_valid,
    input  logic [gom_pkg::POS_W-1:0]           i_pos_x,
    input  logic [gom_pkg::POS_W-1:0]           i_pos_y,
    input  logic signed [gom_pkg::OFF_W-1:0]    i_offset_x,
    input  logic signed [gom_pkg::OFF_W-1:0]    i_offset_y,
    input  logic [gom_pkg::SIZE_W-1:0]          i_width,
    input  logic [gom_pkg::SIZE_W-1:0]          i_height,
    input  logic [gom_pkg::DIR_W-1:0]           i_direction,
    input  logic [gom_pkg::RANGE_W-1:0]         i_max_range,
    output logic                                o_result_valid,
    output logic                                o_hit,
    output logic [gom_pkg::EID_W-1:0]           o_hit_id
);

    localparam int NCELLS  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W  = $clog2(NCELLS);
    localparam int DATA_W  = ID_BITS + 1;
    localparam int PIX_W   = gom_pkg::PIX_W;
    localparam int RANGE_W = gom_pkg::RANGE_W;
    localparam int EID_W   = gom_pkg::EID_W;

    localparam gom_pkg::t_coord COL_LIM  = gom_pkg::t_coord'(GRID_COLS);
    localparam gom_pkg::t_coord ROW_LIM  = gom_pkg::t_coord'(GRID_ROWS);
    localparam gom_pkg::t_coord COL_MAX  = gom_pkg::t_coord'(GRID_COLS - 1);
    localparam gom_pkg::t_coord ROW_MAX  = gom_pkg::t_coord'(GRID_ROWS - 1);
    localparam gom_pkg::t_coord STEP_ONE = gom_pkg::t_coord'(1);
    localparam gom_pkg::t_pix   PIX_ONE  = gom_pkg::t_pix'(1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_SETUP = 6'b001000,
        S_WALK  = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    gom_pkg::t_cmd         r_cmd;
    logic [ID_BITS-1:0]    r_id;
    logic                  r_src;
    gom_pkg::t_dir         r_dir;
    logic [RANGE_W-1:0]    r_range;
    logic [RANGE_W-1:0]    r_step;
    logic                  r_zero_size;
    gom_pkg::t_pix         r_pix [4];
    gom_pkg::t_coord       r_q [4];
    logic [2:0]            r_issue_cnt;
    logic [1:0]            r_q_cnt;
    gom_pkg::t_coord       r_col, r_row, r_r0, r_r1, r_c1;
    logic                  r_p_valid;
    logic                  r_p_in_grid;
    logic [ADDR_W-1:0]     r_p_addr;
    logic                  r_res_valid;
    logic                  r_hit;
    logic [EID_W-1:0]      r_hit_id;

    logic                  accept;
    gom_pkg::t_pix         x0, y0, w_px, h_px, w_half, h_half, rx, ry;
    gom_pkg::t_pix         n_pix [4];
    logic                  div_in_valid, div_valid;
    gom_pkg::t_coord       div_cell;
    gom_pkg::t_coord       c0, c1, r0, r1, dir_dc, dir_dr;
    logic                  setup_skip;
    logic                  cur_in_grid, walk_issue, issue_last;
    logic [ADDR_W-1:0]     row_a, col_a, cur_addr;
    logic [DATA_W-1:0]     rd_data;
    logic                  rd_used;
    logic [ID_BITS-1:0]    rd_owner;
    logic                  eval_hit, rem_we, finish;
    logic                  mem_we, mem_re, mem_ready;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_W-1:0]     mem_wdata;
    logic [RANGE_W-1:0]    range_clamped;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // command pixels: rectangle corners, or probe start point
    assign x0     = $signed(PIX_W'(i_pos_x)) + PIX_W'(i_offset_x);
    assign y0     = $signed(PIX_W'(i_pos_y)) + PIX_W'(i_offset_y);
    assign w_px   = $signed(PIX_W'(i_width));
    assign h_px   = $signed(PIX_W'(i_height));
    assign w_half = $signed(PIX_W'(i_width >> 1));
    assign h_half = $signed(PIX_W'(i_height >> 1));

    always_comb begin
        unique case (gom_pkg::t_dir'(i_direction))
            gom_pkg::DIR_RIGHT: begin
                rx = x0 + w_px;
                ry = y0 + h_half;
            end
            gom_pkg::DIR_LEFT: begin
                rx = x0;
                ry = y0 + h_half;
            end
            gom_pkg::DIR_DOWN: begin
                rx = x0 + w_half;
                ry = y0 + h_px;
            end
            gom_pkg::DIR_UP: begin
                rx = x0 + w_half;
                ry = y0;
            end
        endcase
    end

    always_comb begin
        if (gom_pkg::t_cmd'(i_cmd) == gom_pkg::CMD_PROBE) begin
            n_pix[0] = rx;
            n_pix[1] = rx;
            n_pix[2] = ry;
            n_pix[3] = ry;
        end else begin
            n_pix[0] = x0;
            n_pix[1] = x0 + w_px - PIX_ONE;
            n_pix[2] = y0;
            n_pix[3] = y0 + h_px - PIX_ONE;
        end
    end

    assign range_clamped = (32'(i_max_range) > MAX_STEPS) ? RANGE_W'(MAX_STEPS)
                                                          : i_max_range;

    // shared divider: four pixel values in, four cell coordinates out
    assign div_in_valid = (r_state == S_DIV) && !r_issue_cnt[2];

    gom_cell_div #(
        .CELL_SIZE (CELL_SIZE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_in_valid),
        .i_pix   (r_pix[r_issue_cnt[1:0]]),
        .o_valid (div_valid),
        .o_cell  (div_cell)
    );

    // probe step direction
    always_comb begin
        dir_dc = '0;
        dir_dr = '0;
        unique case (r_dir)
            gom_pkg::DIR_RIGHT: dir_dc = STEP_ONE;
            gom_pkg::DIR_LEFT:  dir_dc = -STEP_ONE;
            gom_pkg::DIR_DOWN:  dir_dr = STEP_ONE;
            gom_pkg::DIR_UP:    dir_dr = -STEP_ONE;
        endcase
    end

    // rectangle span clipped to the grid
    assign c0 = (r_q[0] < 0) ? '0 : r_q[0];
    assign c1 = (r_q[1] > COL_MAX) ? COL_MAX : r_q[1];
    assign r0 = (r_q[2] < 0) ? '0 : r_q[2];
    assign r1 = (r_q[3] > ROW_MAX) ? ROW_MAX : r_q[3];

    assign setup_skip = (r_cmd == gom_pkg::CMD_PROBE)
                        ? (!r_src || (r_range == '0))
                        : (r_zero_size || (c0 > c1) || (r0 > r1));

    // current cell and its table address
    assign cur_in_grid = (r_col >= 0) && (r_col < COL_LIM) &&
                         (r_row >= 0) && (r_row < ROW_LIM);
    assign row_a    = ADDR_W'($unsigned(r_row));
    assign col_a    = ADDR_W'($unsigned(r_col));
    assign cur_addr = ADDR_W'(row_a * ADDR_W'(GRID_COLS)) + col_a;

    assign issue_last = (r_cmd == gom_pkg::CMD_PROBE) ? (r_step == r_range)
                                                      : ((r_row == r_r1) && (r_col == r_c1));

    // evaluate the cell read in the previous cycle
    assign rd_used  = rd_data[DATA_W-1];
    assign rd_owner = rd_data[ID_BITS-1:0];

    assign eval_hit = r_p_valid && r_p_in_grid && rd_used &&
                      (((r_cmd == gom_pkg::CMD_QUERY) && (!r_src || (rd_owner != r_id))) ||
                       ((r_cmd == gom_pkg::CMD_PROBE) && (rd_owner != r_id)));
    assign rem_we   = r_p_valid && (r_cmd == gom_pkg::CMD_REMOVE) &&
                      rd_used && (rd_owner == r_id);

    assign walk_issue = (r_state == S_WALK) && !eval_hit;

    // table access: insert writes at issue, remove writes back after its read
    assign mem_we    = (walk_issue && (r_cmd == gom_pkg::CMD_INSERT)) || rem_we;
    assign mem_waddr = rem_we ? r_p_addr : cur_addr;
    assign mem_wdata = rem_we ? '0 : {1'b1, r_id};
    assign mem_re    = walk_issue && cur_in_grid && (r_cmd != gom_pkg::CMD_INSERT);

    gom_cell_mem #(
        .DEPTH  (NCELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (cur_addr),
        .o_rdata (rd_data),
        .o_ready (mem_ready)
    );

    assign finish = ((r_state == S_SETUP) && setup_skip) ||
                    ((r_state == S_WALK) && eval_hit) ||
                    (r_state == S_DRAIN);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (mem_ready) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_DIV;
            S_DIV:   if (div_valid && (r_q_cnt == 2'd3)) n_state = S_SETUP;
            S_SETUP: n_state = setup_skip ? S_IDLE : S_WALK;
            S_WALK: begin
                if (eval_hit) begin
                    n_state = S_IDLE;
                end else if (issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_res_valid <= 1'b0;
            r_p_valid   <= 1'b0;
            r_issue_cnt <= '0;
            r_q_cnt     <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= finish;
            r_p_valid   <= walk_issue;
            if (accept) begin
                r_issue_cnt <= '0;
                r_q_cnt     <= '0;
            end else begin
                if (div_in_valid) r_issue_cnt <= r_issue_cnt + 3'd1;
                if (div_valid)    r_q_cnt     <= r_q_cnt + 2'd1;
            end
        end
    end

    // command, span and walk registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= gom_pkg::t_cmd'(i_cmd);
            r_id        <= ID_BITS'(i_entity_id);
            r_src       <= i_source_valid;
            r_dir       <= gom_pkg::t_dir'(i_direction);
            r_range     <= range_clamped;
            r_zero_size <= (i_width == '0) || (i_height == '0);
            r_pix       <= n_pix;
        end
        if (div_valid) begin
            r_q[r_q_cnt] <= div_cell;
        end
        if (r_state == S_SETUP) begin
            if (r_cmd == gom_pkg::CMD_PROBE) begin
                r_col  <= r_q[0] + dir_dc;
                r_row  <= r_q[2] + dir_dr;
                r_step <= RANGE_W'(1);
            end else begin
                r_col <= c0;
                r_row <= r0;
                r_r0  <= r0;
                r_r1  <= r1;
                r_c1  <= c1;
            end
        end else if (walk_issue && !issue_last) begin
            if (r_cmd == gom_pkg::CMD_PROBE) begin
                r_col  <= r_col + dir_dc;
                r_row  <= r_row + dir_dr;
                r_step <= r_step + RANGE_W'(1);
            end else if (r_row == r_r1) begin
                // column-major: next column, back to the top row
                r_row <= r_r0;
                r_col <= r_col + STEP_ONE;
            end else begin
                r_row <= r_row + STEP_ONE;
            end
        end
        r_p_in_grid <= cur_in_grid;
        r_p_addr    <= cur_addr;
        if (finish) begin
            r_hit    <= eval_hit;
            r_hit_id <= eval_hit ? EID_W'(rd_owner) : '0;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_hit          = r_hit;
    assign o_hit_id       = r_hit_id;

    `CHK_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted command did not raise busy")
    `CHK_IMPLY(a_result_after_work, i_clk, i_rst_n, o_result_valid, $past(busy), "result without a command in flight")
    `CHK_IMPLY(a_miss_id_zero, i_clk, i_rst_n, o_result_valid && !o_hit, o_hit_id == '0, "nonzero id on a miss")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the grid occupancy map top level.
`timescale 1ns / 1ps

module tb;

    localparam int CELL       = 16;
    localparam int COLS       = 64;
    localparam int ROWS       = 64;
    localparam int IDW        = 10;
    localparam int STEPS_MAX  = 63;
    localparam int NCELLS     = COLS * ROWS;
    localparam int RANDOM_CMDS = 550;
    localparam int ENT_N      = 12;
    // Worst case: every command walks a 33 x 33 span, plus sender gaps and clear pass
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 60;

    // One command as presented on the ports
    typedef struct {
        gom_pkg::t_cmd                     cmd;
        logic [gom_pkg::EID_W-1:0]         eid;
        logic                              src;
        logic [gom_pkg::POS_W-1:0]         px;
        logic [gom_pkg::POS_W-1:0]         py;
        logic signed [gom_pkg::OFF_W-1:0]  ox;
        logic signed [gom_pkg::OFF_W-1:0]  oy;
        logic [gom_pkg::SIZE_W-1:0]        w;
        logic [gom_pkg::SIZE_W-1:0]        h;
        gom_pkg::t_dir                     dir;
        logic [gom_pkg::RANGE_W-1:0]       rng;
    } t_grid_cmd;

    typedef struct packed {
        logic                      hit;
        logic [gom_pkg::EID_W-1:0] hit_id;
    } t_occupancy_answer;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // DUT inputs, known from time zero
    logic                              start          = 1'b0;
    logic [gom_pkg::CMD_W-1:0]         i_cmd          = '0;
    logic [gom_pkg::EID_W-1:0]         i_entity_id    = '0;
    logic                              i_source_valid = 1'b0;
    logic [gom_pkg::POS_W-1:0]         i_pos_x        = '0;
    logic [gom_pkg::POS_W-1:0]         i_pos_y        = '0;
    logic signed [gom_pkg::OFF_W-1:0]  i_offset_x     = '0;
    logic signed [gom_pkg::OFF_W-1:0]  i_offset_y     = '0;
    logic [gom_pkg::SIZE_W-1:0]        i_width        = '0;
    logic [gom_pkg::SIZE_W-1:0]        i_height       = '0;
    logic [gom_pkg::DIR_W-1:0]         i_direction    = '0;
    logic [gom_pkg::RANGE_W-1:0]       i_max_range    = '0;
    logic                              busy;
    logic                              o_result_valid;
    logic                              o_hit;
    logic [gom_pkg::EID_W-1:0]         o_hit_id;

    grid_occupancy_map_top #(
        .CELL_SIZE (CELL),
        .GRID_COLS (COLS),
        .GRID_ROWS (ROWS),
        .ID_BITS   (IDW),
        .MAX_STEPS (STEPS_MAX)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_entity_id    (i_entity_id),
        .i_source_valid (i_source_valid),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_offset_x     (i_offset_x),
        .i_offset_y     (i_offset_y),
        .i_width        (i_width),
        .i_height       (i_height),
        .i_direction    (i_direction),
        .i_max_range    (i_max_range),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .o_hit_id       (o_hit_id)
    );

    // Shadow copy of the cell table
    logic [gom_pkg::EID_W-1:0] shadow_owner [0:NCELLS-1];
    logic                      shadow_used  [0:NCELLS-1];

    t_grid_cmd         pending_cmds[$];
    t_occupancy_answer expected_answers[$];
    t_grid_cmd         on_bus;
    t_occupancy_answer next_answer;
    int                n_total   = 0;
    int                n_issued  = 0;
    int                n_sent    = 0;
    int                n_errors  = 0;

    // Entities that move around the map during the random part
    int                ent_x   [ENT_N];
    int                ent_y   [ENT_N];
    int                ent_w   [ENT_N];
    int                ent_h   [ENT_N];
    int                ent_ox  [ENT_N];
    int                ent_oy  [ENT_N];
    int                ent_id  [ENT_N];
    bit                ent_on  [ENT_N];

    // Floor division by the cell size, also for negative pixels
    function automatic int cell_floor(input int v);
        if (v >= 0) return v / CELL;
        return -((-v + CELL - 1) / CELL);
    endfunction

    // Apply one command to the shadow table and work out its answer
    function automatic void resolve_command(input t_grid_cmd c, output t_occupancy_answer ans);
        int  x0, y0, w, h, c0, c1, r0, r1, col, row, k, rx, ry, dx, dy, s, steps;
        ans = '0;
        x0 = int'(c.px) + int'(c.ox);
        y0 = int'(c.py) + int'(c.oy);
        w  = int'(c.w);
        h  = int'(c.h);
        if (c.cmd != gom_pkg::CMD_PROBE) begin
            if (w > 0 && h > 0) begin
                c0 = cell_floor(x0);
                c1 = cell_floor(x0 + w - 1);
                r0 = cell_floor(y0);
                r1 = cell_floor(y0 + h - 1);
                if (c0 < 0) c0 = 0;
                if (r0 < 0) r0 = 0;
                if (c1 > COLS - 1) c1 = COLS - 1;
                if (r1 > ROWS - 1) r1 = ROWS - 1;
                // column-major walk; a query stops at the first foreign owner
                for (col = c0; col <= c1 && !ans.hit; col++) begin
                    for (row = r0; row <= r1 && !ans.hit; row++) begin
                        k = row * COLS + col;
                        case (c.cmd)
                            gom_pkg::CMD_INSERT: begin
                                shadow_owner[k] = c.eid;
                                shadow_used[k]  = 1'b1;
                            end
                            gom_pkg::CMD_REMOVE: begin
                                if (shadow_used[k] && shadow_owner[k] == c.eid) begin
                                    shadow_used[k]  = 1'b0;
                                    shadow_owner[k] = '0;
                                end
                            end
                            default: begin
                                if (shadow_used[k] && (!c.src || shadow_owner[k] != c.eid)) begin
                                    ans.hit    = 1'b1;
                                    ans.hit_id = shadow_owner[k];
                                end
                            end
                        endcase
                    end
                end
            end
        end else if (c.src) begin
            dx = 0;
            dy = 0;
            case (c.dir)
                gom_pkg::DIR_RIGHT: begin dx = CELL;  rx = x0 + w;     ry = y0 + h / 2; end
                gom_pkg::DIR_LEFT:  begin dx = -CELL; rx = x0;         ry = y0 + h / 2; end
                gom_pkg::DIR_DOWN:  begin dy = CELL;  rx = x0 + w / 2; ry = y0 + h;     end
                default:            begin dy = -CELL; rx = x0 + w / 2; ry = y0;         end
            endcase
            steps = (int'(c.rng) > STEPS_MAX) ? STEPS_MAX : int'(c.rng);
            for (s = 1; s <= steps && !ans.hit; s++) begin
                col = cell_floor(rx + dx * s);
                row = cell_floor(ry + dy * s);
                if (col >= 0 && col < COLS && row >= 0 && row < ROWS) begin
                    k = row * COLS + col;
                    if (shadow_used[k] && shadow_owner[k] != c.eid) begin
                        ans.hit    = 1'b1;
                        ans.hit_id = shadow_owner[k];
                    end
                end
            end
        end
    endfunction

    function automatic t_grid_cmd mk_cmd(input gom_pkg::t_cmd cmd, input int eid, input int src,
                                         input int px, input int py, input int ox, input int oy,
                                         input int w, input int h, input gom_pkg::t_dir dir,
                                         input int rng);
        t_grid_cmd c;
        c.cmd = cmd;
        c.eid = eid[gom_pkg::EID_W-1:0];
        c.src = src[0];
        c.px  = px[gom_pkg::POS_W-1:0];
        c.py  = py[gom_pkg::POS_W-1:0];
        c.ox  = ox[gom_pkg::OFF_W-1:0];
        c.oy  = oy[gom_pkg::OFF_W-1:0];
        c.w   = w[gom_pkg::SIZE_W-1:0];
        c.h   = h[gom_pkg::SIZE_W-1:0];
        c.dir = dir;
        c.rng = rng[gom_pkg::RANGE_W-1:0];
        return c;
    endfunction

    // Command over the current rectangle of one entity
    function automatic t_grid_cmd entity_cmd(input gom_pkg::t_cmd cmd, input int e);
        return mk_cmd(cmd, ent_id[e], 1, ent_x[e], ent_y[e], ent_ox[e], ent_oy[e],
                      ent_w[e], ent_h[e], gom_pkg::DIR_RIGHT, 0);
    endfunction

    // Positions are mostly packed in one corner so that entities meet
    function automatic int cluster_coord();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 300);
        return $urandom_range(0, 1023);
    endfunction

    function automatic int sender_idle_pct();
        if (n_issued < n_total / 3) return 18;
        if (n_issued < (2 * n_total) / 3) return 74;
        return 0;
    endfunction

    task automatic report_mismatch(input string why, input t_occupancy_answer want);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t: %s: expected hit=%0b id=%0d, got hit=%0b id=%0d",
                     $realtime, why, want.hit, want.hit_id, o_hit, o_hit_id);
    endtask

    // Stimulus: directed commands first, then entity traffic with some noise
    initial begin
        t_grid_cmd c;
        int        pick, e, n_random, i, rng_pick;
        for (i = 0; i < NCELLS; i++) begin
            shadow_owner[i] = '0;
            shadow_used[i]  = 1'b0;
        end

        // single cell owned by id 5, then queries from owner, stranger, no source
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_INSERT, 5, 1, 32, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_QUERY, 5, 1, 32, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_QUERY, 6, 1, 32, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_QUERY, 5, 0, 30, 30, 0, 0, 8, 8,
                                      gom_pkg::DIR_RIGHT, 0));
        // probes: hit, no source, zero range
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_PROBE, 7, 1, 0, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 5));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_PROBE, 7, 0, 0, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 5));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_PROBE, 7, 1, 0, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        // remove by a non-owner leaves the cell, remove by the owner clears it
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_REMOVE, 6, 1, 32, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_QUERY, 6, 1, 32, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_REMOVE, 5, 1, 32, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_QUERY, 5, 0, 32, 32, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        // largest rectangle, partly at negative pixels, owned by the top id
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_INSERT, 1023, 1, 0, 0, -128, -128, 511, 511,
                                      gom_pkg::DIR_RIGHT, 0));
        // insert wholly off the grid is dropped; id 0 owns the far corner
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_INSERT, 0, 1, 1023, 1023, 127, 127, 256, 256,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_INSERT, 0, 1, 1008, 1008, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_QUERY, 1, 1, 1000, 1000, 0, 0, 511, 511,
                                      gom_pkg::DIR_RIGHT, 0));
        // zero-size rectangles touch nothing
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_QUERY, 1, 0, 100, 100, 0, 0, 0, 16,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_INSERT, 9, 1, 500, 500, 0, 0, 16, 0,
                                      gom_pkg::DIR_RIGHT, 0));
        // probes in every direction, full range
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_PROBE, 3, 1, 600, 100, 0, 0, 16, 16,
                                      gom_pkg::DIR_LEFT, 63));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_PROBE, 3, 1, 100, 700, 0, 0, 16, 16,
                                      gom_pkg::DIR_UP, 63));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_PROBE, 3, 1, 1008, 900, 0, 0, 16, 16,
                                      gom_pkg::DIR_DOWN, 63));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_PROBE, 3, 1, 900, 1008, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 63));
        // own cells never stop a probe
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_PROBE, 1023, 1, 50, 50, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 3));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_REMOVE, 1023, 1, 0, 0, -128, -128, 511, 511,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_QUERY, 2, 0, 0, 0, -128, -128, 511, 511,
                                      gom_pkg::DIR_RIGHT, 0));
        pending_cmds.push_back(mk_cmd(gom_pkg::CMD_QUERY, 0, 1, 1008, 1008, 0, 0, 16, 16,
                                      gom_pkg::DIR_RIGHT, 0));

        // entity set
        for (e = 0; e < ENT_N; e++) begin
            ent_id[e] = $urandom_range(0, 1023);
            ent_x[e]  = cluster_coord();
            ent_y[e]  = cluster_coord();
            ent_w[e]  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 40);
            ent_h[e]  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 40);
            ent_ox[e] = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 32) - 16;
            ent_oy[e] = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 32) - 16;
            ent_on[e] = 1'b0;
        end

        n_random = 0;
        while (n_random < RANDOM_CMDS) begin
            pick = $urandom_range(0, 99);
            e    = $urandom_range(0, ENT_N - 1);
            if (pick < 12) begin
                // noise: every field fully random
                c = mk_cmd(gom_pkg::t_cmd'($urandom_range(0, 3)), $urandom_range(0, 1023),
                           $urandom_range(0, 1), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 511),
                           $urandom_range(0, 511), gom_pkg::t_dir'($urandom_range(0, 3)),
                           $urandom_range(0, 63));
                pending_cmds.push_back(c);
                n_random++;
            end else if (pick < 42) begin
                // move: remove at the old place, insert at the new one
                if (ent_on[e]) begin
                    pending_cmds.push_back(entity_cmd(gom_pkg::CMD_REMOVE, e));
                    n_random++;
                end
                if (ent_on[e] && $urandom_range(0, 3) != 0) begin
                    ent_x[e] = ent_x[e] + $urandom_range(0, 64) - 32;
                    ent_y[e] = ent_y[e] + $urandom_range(0, 64) - 32;
                    if (ent_x[e] < 0) ent_x[e] = 0;
                    if (ent_y[e] < 0) ent_y[e] = 0;
                    if (ent_x[e] > 1023) ent_x[e] = 1023;
                    if (ent_y[e] > 1023) ent_y[e] = 1023;
                end else begin
                    ent_x[e] = cluster_coord();
                    ent_y[e] = cluster_coord();
                end
                pending_cmds.push_back(entity_cmd(gom_pkg::CMD_INSERT, e));
                ent_on[e] = 1'b1;
                n_random++;
            end else if (pick < 50) begin
                // despawn
                pending_cmds.push_back(entity_cmd(gom_pkg::CMD_REMOVE, e));
                ent_on[e] = 1'b0;
                n_random++;
            end else if (pick < 72) begin
                c = entity_cmd(gom_pkg::CMD_QUERY, e);
                if ($urandom_range(0, 1) == 0) begin
                    c = mk_cmd(gom_pkg::CMD_QUERY, ent_id[e], 1, cluster_coord(),
                               cluster_coord(), ent_ox[e], ent_oy[e], $urandom_range(1, 64),
                               $urandom_range(1, 64), gom_pkg::DIR_RIGHT, 0);
                end
                c.src = ($urandom_range(0, 9) != 0);
                pending_cmds.push_back(c);
                n_random++;
            end else begin
                rng_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(1, 24);
                c = mk_cmd(gom_pkg::CMD_PROBE, ent_id[e], int'($urandom_range(0, 9) != 0),
                           ent_x[e], ent_y[e], ent_ox[e], ent_oy[e], ent_w[e], ent_h[e],
                           gom_pkg::t_dir'($urandom_range(0, 3)), rng_pick);
                pending_cmds.push_back(c);
                n_random++;
            end
        end
        n_total = pending_cmds.size();
    end

    // Reset once at the start
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: present the next command, hold it until the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && busy === 1'b0) begin
                resolve_command(on_bus, next_answer);
                expected_answers.push_back(next_answer);
                n_sent++;
            end
            if (!start || busy === 1'b0) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    on_bus = pending_cmds.pop_front();
                    n_issued++;
                    i_cmd          <= on_bus.cmd;
                    i_entity_id    <= on_bus.eid;
                    i_source_valid <= on_bus.src;
                    i_pos_x        <= on_bus.px;
                    i_pos_y        <= on_bus.py;
                    i_offset_x     <= on_bus.ox;
                    i_offset_y     <= on_bus.oy;
                    i_width        <= on_bus.w;
                    i_height       <= on_bus.h;
                    i_direction    <= on_bus.dir;
                    i_max_range    <= on_bus.rng;
                    start          <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each result strobe against the oldest expected answer
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("result with no command outstanding", '0);
            end else if (o_hit !== expected_answers[0].hit ||
                         o_hit_id !== expected_answers[0].hit_id) begin
                report_mismatch("answer mismatch", expected_answers.pop_front());
            end else begin
                void'(expected_answers.pop_front());
            end
        end
    end

    // End of run
    initial begin
        @(posedge i_clk);
        while (n_total == 0 || n_sent < n_total) @(posedge i_clk);
        while (expected_answers.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[grid_occupancy_map_top] OK");
        end else begin
            $display("[grid_occupancy_map_top] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[grid_occupancy_map_top] ERROR");
        $finish;
    end

endmodule
